/* hdl/spwm_pkg.sv */
// Shared types, constants and the half-sine table of the sine PWM duty generator.
package spwm_pkg;

   // Fixed field widths of the block.
   localparam int PERIOD_W   = 12;
   localparam int INDEX_W    = 11;
   localparam int DUTY_W     = 12;
   localparam int ROM_W      = 16;
   localparam int ROM_IDX_W  = 6;

   // The largest period and the number of half-sine table entries.
   localparam int MAX_PERIOD    = 2048;
   localparam int TABLE_ENTRIES = 50;
   localparam int TABLE_STEPS   = 2 * TABLE_ENTRIES;

   // The dividend is TABLE_STEPS times the sample index, below 2^18.
   localparam int DIVIDEND_W = 18;
   localparam int DIV_CNT_W  = 5;
   localparam int QUOT_W     = 7;
   localparam int PROD_W     = ROM_W + PERIOD_W;
   localparam int ROUND_BIT  = 15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LOOKUP,
      ST_MUL_LOW,
      ST_MUL_HIGH,
      ST_EMIT
   } spwm_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic lookup;
      logic mul_low;
      logic mul_high;
      logic emit;
   } spwm_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } spwm_status_type;

   // Half-sine values in unsigned Q1.15.
   function automatic logic [ROM_W-1:0] half_sine_rom(input logic [ROM_IDX_W-1:0] idx);
      logic [ROM_W-1:0] val;
      unique case (idx)
         6'd0:  val = 16'd0;
         6'd1:  val = 16'd2058;
         6'd2:  val = 16'd4107;
         6'd3:  val = 16'd6140;
         6'd4:  val = 16'd8149;
         6'd5:  val = 16'd10126;
         6'd6:  val = 16'd12063;
         6'd7:  val = 16'd13952;
         6'd8:  val = 16'd15786;
         6'd9:  val = 16'd17558;
         6'd10: val = 16'd19261;
         6'd11: val = 16'd20887;
         6'd12: val = 16'd22431;
         6'd13: val = 16'd23887;
         6'd14: val = 16'd25248;
         6'd15: val = 16'd26510;
         6'd16: val = 16'd27667;
         6'd17: val = 16'd28715;
         6'd18: val = 16'd29649;
         6'd19: val = 16'd30467;
         6'd20: val = 16'd31164;
         6'd21: val = 16'd31739;
         6'd22: val = 16'd32188;
         6'd23: val = 16'd32510;
         6'd24: val = 16'd32703;
         6'd25: val = 16'd32768;
         6'd26: val = 16'd32703;
         6'd27: val = 16'd32510;
         6'd28: val = 16'd32188;
         6'd29: val = 16'd31739;
         6'd30: val = 16'd31164;
         6'd31: val = 16'd30467;
         6'd32: val = 16'd29649;
         6'd33: val = 16'd28715;
         6'd34: val = 16'd27667;
         6'd35: val = 16'd26510;
         6'd36: val = 16'd25248;
         6'd37: val = 16'd23887;
         6'd38: val = 16'd22431;
         6'd39: val = 16'd20887;
         6'd40: val = 16'd19261;
         6'd41: val = 16'd17558;
         6'd42: val = 16'd15786;
         6'd43: val = 16'd13952;
         6'd44: val = 16'd12063;
         6'd45: val = 16'd10126;
         6'd46: val = 16'd8149;
         6'd47: val = 16'd6140;
         6'd48: val = 16'd4107;
         6'd49: val = 16'd2058;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

endpackage

/* hdl/spwm_ctrl.sv */
// Controller state machine that sequences one duty computation.
module spwm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  spwm_pkg::spwm_status_type status,
   output logic                     req_stall,
   output spwm_pkg::spwm_cmd_type   cmd
);
   import spwm_pkg::*;

   spwm_state_type state_ff;
   spwm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_last) state_in = ST_LOOKUP;
         end
         ST_LOOKUP:   state_in = ST_MUL_LOW;
         ST_MUL_LOW:  state_in = ST_MUL_HIGH;
         ST_MUL_HIGH: state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_DIV:      cmd.div_step = 1'b1;
         ST_LOOKUP:   cmd.lookup   = 1'b1;
         ST_MUL_LOW:  cmd.mul_low  = 1'b1;
         ST_MUL_HIGH: cmd.mul_high = 1'b1;
         ST_EMIT:     cmd.emit     = status.out_free;
         default:     cmd          = '0;
      endcase
   end

endmodule

/* hdl/spwm_datapath.sv */
// Datapath: sample counter, serial divider, table lookup, multiplier and output register.
module spwm_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [spwm_pkg::PERIOD_W-1:0]    period,
   input  logic                             req_restart,
   input  spwm_pkg::spwm_cmd_type           cmd,
   output spwm_pkg::spwm_status_type        status,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [spwm_pkg::DUTY_W-1:0]      rsp_first_half_duty,
   output logic [spwm_pkg::DUTY_W-1:0]      rsp_second_half_duty,
   output logic [spwm_pkg::INDEX_W-1:0]     rsp_sample_index,
   output logic                             rsp_last
);
   import spwm_pkg::*;

   logic [INDEX_W-1:0]    counter_ff, counter_in;
   logic [INDEX_W-1:0]    n_ff, n_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [PERIOD_W-1:0]   rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROM_W-1:0]      v1_ff, v2_ff;
   logic [PERIOD_W-1:0]   pmr_ff;
   logic [PROD_W-1:0]     acc_ff, prod_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]     first_ff, second_ff;
   logic [INDEX_W-1:0]    index_ff;
   logic                  last_ff;

   logic [DIVIDEND_W-1:0] scaled;
   logic [PERIOD_W:0]     shifted, trial;
   logic                  ge;
   logic [QUOT_W-1:0]     quot;
   logic [ROM_IDX_W-1:0]  idx1, idx2;
   logic [ROM_W-1:0]      mul_a;
   logic [PERIOD_W-1:0]   mul_b;
   logic [PROD_W-1:0]     mul_res;
   logic [PROD_W-1:0]     num;
   logic [DUTY_W-1:0]     duty;
   logic                  first_half;
   logic [PERIOD_W-1:0]   n_next;

   // Sample position of the new transaction and the following one.
   always_comb begin
      if (req_restart || ({1'b0, counter_ff} >= period)) begin
         n_in = '0;
      end else begin
         n_in = counter_ff;
      end
      n_next = {1'b0, n_in} + 12'd1;
      if (n_next >= period) begin
         counter_in = '0;
      end else begin
         counter_in = n_next[INDEX_W-1:0];
      end
      // Times one hundred as three shifted copies.
      scaled = {1'b0, n_in, 6'b0} + {2'b0, n_in, 5'b0} + {5'b0, n_in, 2'b0};
   end

   // One restoring division step per cycle.
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge      = shifted >= {1'b0, period};
      trial   = shifted - {1'b0, period};
      rem_in  = ge ? trial[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
      quo_in  = {quo_ff[DIVIDEND_W-2:0], ge};
      cnt_in  = cnt_ff + 5'd1;
   end

   assign status.div_last = (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1));

   // The quotient stays below two table lengths, so one subtraction wraps it.
   always_comb begin
      quot = quo_ff[QUOT_W-1:0];
      if (quot >= QUOT_W'(TABLE_ENTRIES)) begin
         idx1 = ROM_IDX_W'(quot - QUOT_W'(TABLE_ENTRIES));
      end else begin
         idx1 = quot[ROM_IDX_W-1:0];
      end
      if (idx1 == ROM_IDX_W'(TABLE_ENTRIES - 1)) begin
         idx2 = '0;
      end else begin
         idx2 = idx1 + 6'd1;
      end
   end

   // One shared multiplier for both interpolation products.
   assign mul_a   = cmd.mul_high ? v2_ff : v1_ff;
   assign mul_b   = cmd.mul_high ? rem_ff : pmr_ff;
   assign mul_res = {{PERIOD_W{1'b0}}, mul_a} * {{ROM_W{1'b0}}, mul_b};

   // Round half up and drop the fraction.
   always_comb begin
      num        = acc_ff + prod_ff + PROD_W'(1 << (ROUND_BIT - 1));
      duty       = num[ROUND_BIT+DUTY_W-1:ROUND_BIT];
      first_half = {n_ff, 1'b0} < period;
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) counter_ff <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff   <= n_in;
         quo_ff <= scaled;
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
      if (cmd.lookup) begin
         v1_ff  <= half_sine_rom(idx1);
         v2_ff  <= half_sine_rom(idx2);
         pmr_ff <= period - rem_ff;
      end
      if (cmd.mul_low)  acc_ff  <= mul_res;
      if (cmd.mul_high) prod_ff <= mul_res;
      if (cmd.emit) begin
         first_ff  <= first_half ? duty : '0;
         second_ff <= first_half ? '0 : duty;
         index_ff  <= n_ff;
         last_ff   <= ({1'b0, n_ff} == (period - 12'd1));
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_first_half_duty  = first_ff;
   assign rsp_second_half_duty = second_ff;
   assign rsp_sample_index     = index_ff;
   assign rsp_last             = last_ff;

endmodule

/* hdl/sine_pwm_duty_generator.sv */
// Top level of the sine PWM duty generator: period register, controller and datapath.
//
// Each request transaction is one PWM tick and yields exactly one response transaction
// carrying the duty for the current sample of a sine period, read from a 50-entry
// half-sine table with linear interpolation between neighboring entries.
// The request channel carries req_restart, which starts the period over at sample zero
// before the tick is computed. The response carries the two channel duties (at most one of
// them is nonzero), the sample index and a flag for the final sample of the period.
// The period is set through csr_write_enable and csr_period_samples; it resets to 100
// and should only be changed while no transaction is in flight. Zero acts as one and
// values above 2048 act as 2048.
// Each request is computed in order: the bit-serial divider splits the scaled sample index
// into table index and remainder, one table lookup reads the two neighboring entries, the
// shared multiplier forms the low and high products and the sum is rounded into the output
// register. The controller then returns to idle before it can accept again, so no new request
// is taken while a computation is in flight.
// A response stalled by rsp_stall holds in the output register while the next request
// is already accepted and computed; the block waits only if that new result is ready
// before the old one leaves. Synchronous reset clears the sample counter and the response
// valid and sets the period register to 100.
module sine_pwm_duty_generator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_restart,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [spwm_pkg::DUTY_W-1:0]      rsp_first_half_duty,
   output logic [spwm_pkg::DUTY_W-1:0]      rsp_second_half_duty,
   output logic [spwm_pkg::INDEX_W-1:0]     rsp_sample_index,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [spwm_pkg::PERIOD_W-1:0]    csr_period_samples
);
   import spwm_pkg::*;

   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] period_eff;
   spwm_cmd_type        cmd;
   spwm_status_type     status;

   // The period register takes every write; the clamp is applied on the way out.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 12'd100;
      end else if (csr_write_enable) begin
         period_ff <= csr_period_samples;
      end
   end

   always_comb begin
      priority if (period_ff == '0) begin
         period_eff = 12'd1;
      end else if (period_ff > PERIOD_W'(MAX_PERIOD)) begin
         period_eff = PERIOD_W'(MAX_PERIOD);
      end else begin
         period_eff = period_ff;
      end
   end

   spwm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   spwm_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .period               (period_eff),
      .req_restart          (req_restart),
      .cmd                  (cmd),
      .status               (status),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_first_half_duty  (rsp_first_half_duty),
      .rsp_second_half_duty (rsp_second_half_duty),
      .rsp_sample_index     (rsp_sample_index),
      .rsp_last             (rsp_last)
   );

   // At most one channel carries a nonzero duty in any response.
   a_one_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_half_duty == '0 || rsp_second_half_duty == '0))
      else $error("both channel duties nonzero");

   // Interpolated duty never exceeds full scale.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_half_duty <= period_eff && rsp_second_half_duty <= period_eff))
      else $error("duty above period");

   // The reported sample lies inside the period.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_sample_index} < period_eff))
      else $error("sample index outside period");

   // An accepted request keeps the controller busy on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !cmd.load))
      else $error("request accepted twice in a row");

endmodule
